>>> design/hcbe_pkg.sv
// Shared types, sizes and key lookup for the Hill cipher block encrypt core.
package hcbe_pkg;

   localparam int MAX_KEY_SIZE = 3;
   localparam int BYTE_W       = 8;
   localparam int ROW_W        = MAX_KEY_SIZE * BYTE_W;
   localparam int SIZE_W       = 2;
   localparam int CIPHER_W     = 18;
   localparam int PROD_W       = 2 * BYTE_W;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;
   localparam int QCNT_W       = 3;
   localparam int CSR_IDX_W    = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW_0 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW_1 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW_2 = 2'd3;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [ROW_W-1:0]  key_row_type;

   // One gathered block, zero padded, with its size and end mark
   typedef struct packed {
      byte_type [MAX_KEY_SIZE-1:0] bytes;
      logic [SIZE_W-1:0]           size;
      logic                        last;
   } blk_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Pick key entry of one column out of a packed row
   function automatic byte_type key_entry(input key_row_type row, input logic [SIZE_W-1:0] col);
      byte_type e;
      case (col)
         2'd0:    e = row[BYTE_W-1:0];
         2'd1:    e = row[2*BYTE_W-1:BYTE_W];
         2'd2:    e = row[3*BYTE_W-1:2*BYTE_W];
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

>>> design/hcbe_front.sv
// Front end: gathers request bytes into blocks and pushes finished blocks.
module hcbe_front import hcbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_message_byte,
   input  logic              req_end_of_message,
   input  logic [SIZE_W-1:0] key_size,
   input  q_stat_type        q_stat,
   output logic              push,
   output blk_type           push_blk
);

   logic [SIZE_W-1:0]           pos_ff, pos_in;
   byte_type [MAX_KEY_SIZE-1:0] bytes_ff, bytes_in;
   byte_type [MAX_KEY_SIZE-1:0] merged;
   logic [SIZE_W-1:0]           size_eff;
   logic [SIZE_W:0]             pos_next;
   logic                        accept;
   logic                        done;

   // Size zero counts as one
   assign size_eff = (key_size == '0) ? SIZE_W'(1) : key_size;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;

   // Drop the new byte into its slot
   always_comb begin
      merged = bytes_ff;
      if (pos_ff < SIZE_W'(MAX_KEY_SIZE)) begin
         merged[pos_ff] = req_message_byte;
      end
   end

   assign pos_next = {1'b0, pos_ff} + (SIZE_W+1)'(1);
   assign done     = (pos_next >= {1'b0, size_eff}) || req_end_of_message;

   assign push          = accept && done;
   assign push_blk.bytes = merged;
   assign push_blk.size  = size_eff;
   assign push_blk.last  = req_end_of_message;

   // Advance fill position, clear buffer when a block leaves
   always_comb begin
      pos_in   = pos_ff;
      bytes_in = bytes_ff;
      if (accept) begin
         if (done) begin
            pos_in   = '0;
            bytes_in = '0;
         end else begin
            pos_in   = pos_next[SIZE_W-1:0];
            bytes_in = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         bytes_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         bytes_ff <= bytes_in;
      end
   end

endmodule

>>> design/hcbe_queue.sv
// Short block queue between the front and the back.
module hcbe_queue import hcbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  blk_type    push_blk,
   input  logic       pop,
   output blk_type    head,
   output q_stat_type q_stat
);

   blk_type           mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head         = mem[rd_ptr_ff];

   // Move pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed block
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_blk;
      end
   end

endmodule

>>> design/hcbe_back.sv
// Back end: walks head block columns, registering one result per unstalled cycle.
module hcbe_back import hcbe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  blk_type             head,
   input  q_stat_type          q_stat,
   output logic                pop,
   input  key_row_type         key_row_0,
   input  key_row_type         key_row_1,
   input  key_row_type         key_row_2,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CIPHER_W-1:0] rsp_cipher_value,
   output logic                rsp_last_of_block,
   output logic                rsp_last_of_message
);

   logic [SIZE_W-1:0]   col_ff, col_in;
   logic                valid_ff, valid_in;
   logic [CIPHER_W-1:0] value_ff, value_in;
   logic                lob_ff, lob_in;
   logic                lom_ff, lom_in;
   logic                fire;
   logic                last_col;
   logic [PROD_W-1:0]   prod0, prod1, prod2;
   byte_type            b1, b2;

   assign fire     = !q_stat.empty && (!valid_ff || !rsp_stall);
   assign last_col = (col_ff == head.size - SIZE_W'(1));
   assign pop      = fire && last_col;

   // Bytes beyond the block size do not count
   assign b1 = (head.size > SIZE_W'(1)) ? head.bytes[1] : '0;
   assign b2 = (head.size > SIZE_W'(2)) ? head.bytes[2] : '0;

   assign prod0 = head.bytes[0] * key_entry(key_row_0, col_ff);
   assign prod1 = b1 * key_entry(key_row_1, col_ff);
   assign prod2 = b2 * key_entry(key_row_2, col_ff);

   // Advance column, load output register
   always_comb begin
      col_in   = col_ff;
      valid_in = valid_ff;
      value_in = value_ff;
      lob_in   = lob_ff;
      lom_in   = lom_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (fire) begin
         valid_in = 1'b1;
         value_in = CIPHER_W'(prod0) + CIPHER_W'(prod1) + CIPHER_W'(prod2);
         lob_in   = last_col;
         lom_in   = last_col && head.last;
         col_in   = last_col ? '0 : col_ff + SIZE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      lob_ff   <= lob_in;
      lom_ff   <= lom_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_cipher_value    = value_ff;
   assign rsp_last_of_block   = lob_ff;
   assign rsp_last_of_message = lom_ff;

endmodule

>>> design/hill_cipher_block_encrypt_core.sv
// Top level of the Hill cipher block encrypt core: key registers, front, queue, back.
//
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   message_byte[7:0], end_of_message
//  rsp_      out        rsp_valid/rsp_stall   cipher_value[17:0], last_of_block, last_of_message
//  csr_      in         csr_valid/csr_ready   csr_index[1:0], csr_data[23:0]
//
// One request is taken per cycle while req_stall is low; a block of key size n
// yields n results, one per cycle from the back's three 8x8 multipliers while
// rsp_stall allows, so the result port sets the rate. A full four-entry block
// queue raises req_stall; the back registers each result. csr_ready is always high.
// Reset is synchronous: key size 3, key rows zero, buffer and queue empty.
module hill_cipher_block_encrypt_core import hcbe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_message_byte,
   input  logic                 req_end_of_message,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CIPHER_W-1:0]  rsp_cipher_value,
   output logic                 rsp_last_of_block,
   output logic                 rsp_last_of_message,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]     csr_data
);

   logic [SIZE_W-1:0] key_size_ff, key_size_in;
   key_row_type       row0_ff, row0_in;
   key_row_type       row1_ff, row1_in;
   key_row_type       row2_ff, row2_in;
   logic              csr_wr;
   logic              push;
   logic              pop;
   blk_type           push_blk;
   blk_type           head;
   q_stat_type        q_stat;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // Write configuration registers
   always_comb begin
      key_size_in = key_size_ff;
      row0_in     = row0_ff;
      row1_in     = row1_ff;
      row2_in     = row2_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_KEY_SIZE:  key_size_in = csr_data[SIZE_W-1:0];
            CSR_KEY_ROW_0: row0_in     = csr_data;
            CSR_KEY_ROW_1: row1_in     = csr_data;
            CSR_KEY_ROW_2: row2_in     = csr_data;
            default:       key_size_in = key_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= SIZE_W'(MAX_KEY_SIZE);
         row0_ff     <= '0;
         row1_ff     <= '0;
         row2_ff     <= '0;
      end else begin
         key_size_ff <= key_size_in;
         row0_ff     <= row0_in;
         row1_ff     <= row1_in;
         row2_ff     <= row2_in;
      end
   end

   hcbe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_message_byte   (req_message_byte),
      .req_end_of_message (req_end_of_message),
      .key_size           (key_size_ff),
      .q_stat             (q_stat),
      .push               (push),
      .push_blk           (push_blk)
   );

   hcbe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_blk (push_blk),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   hcbe_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .q_stat              (q_stat),
      .pop                 (pop),
      .key_row_0           (row0_ff),
      .key_row_1           (row1_ff),
      .key_row_2           (row2_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cipher_value    (rsp_cipher_value),
      .rsp_last_of_block   (rsp_last_of_block),
      .rsp_last_of_message (rsp_last_of_message)
   );

   // Never push into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !q_stat.full)
      else $error("block pushed into full queue");

   // Never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_stat.empty)
      else $error("block popped from empty queue");

   // End of message only on the last column of a block
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_message) |-> rsp_last_of_block)
      else $error("message end without block end");

   // A request marked as message end always leaves a block in the queue
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_end_of_message) |=> !q_stat.empty)
      else $error("message end did not reach the queue");

endmodule
